// File: sv/flex_sensor_servo_pwm_controller_assert.svh
// assertion macros used by the checker file
`ifndef FLEX_SENSOR_SERVO_PWM_CONTROLLER_ASSERT_SVH
`define FLEX_SENSOR_SERVO_PWM_CONTROLLER_ASSERT_SVH

// same-cycle implication, off while in reset
`define FSSPC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsspc assertion failed");

// next-cycle implication, off while in reset
`define FSSPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsspc assertion failed");

`endif

// File: sv/fsspc_pkg.sv
`default_nettype none

package fsspc_pkg;

  // field widths
  localparam int RAW_W      = 10;
  localparam int CH_FIELD_W = 3;
  localparam int ANGLE_W    = 7;
  localparam int LINES_W    = 5;
  localparam int PW_W       = 7;
  localparam int DB_W       = 7;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_CAL_FLAT = 2'd0;
  localparam logic [1:0] REG_CAL_BENT = 2'd1;
  localparam logic [1:0] REG_DEADBAND = 2'd2;

  localparam logic [RAW_W-1:0] CAL_FLAT_RESET = 10'd256;
  localparam logic [RAW_W-1:0] CAL_BENT_RESET = 10'd59;
  localparam logic [DB_W-1:0]  DEADBAND_RESET = 7'd1;

  // opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // angle and pulse math
  localparam int ANGLE_SPAN  = 90;
  localparam int PULSE_RESET = 50;
  // floor(5*a/9) == (a * 2280) >> 12 for a in 0..90
  localparam int TICK_RECIP  = 2280;
  localparam int RECIP_SHIFT = 12;
  localparam int PROD_W      = 18;

  // angle divider
  localparam int DVD_W = 17;
  localparam int DVS_W = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEAN,
    ST_ANGLE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic mean_start;
    logic angle_start;
    logic apply;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic avg_done;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/fsspc_if.sv
`default_nettype none

interface fsspc_in_if;
  import fsspc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [CH_FIELD_W-1:0] channel;
  logic [RAW_W-1:0]      raw_sample;

  modport source (output valid, output op, output channel, output raw_sample, input ready);
  modport sink   (input valid, input op, input channel, input raw_sample, output ready);
endinterface

interface fsspc_out_if;
  import fsspc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LINES_W-1:0] servo_lines;
  logic               angle_valid;
  logic [ANGLE_W-1:0] finger_angle;
  logic               pulse_updated;

  modport source (output valid, output servo_lines, output angle_valid,
                  output finger_angle, output pulse_updated, input ready);
  modport sink   (input valid, input servo_lines, input angle_valid,
                  input finger_angle, input pulse_updated, output ready);
endinterface

`default_nettype wire

// File: sv/fsspc_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module fsspc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fsspc_pkg::DVD_W-1:0] dividend,
  input  logic [fsspc_pkg::DVS_W-1:0] divisor,
  output logic                        done,
  output logic [fsspc_pkg::DVD_W-1:0] quotient
);
  import fsspc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_sub;
  logic           fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    fits    = rem_sh >= {1'b0, dvs_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: sv/fsspc_ctrl.sv
`default_nettype none

module fsspc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fsspc_pkg::dp_stat_t   stat,
  output fsspc_pkg::ctrl_cmd_t  cmd
);
  import fsspc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.avg_done ? ST_MEAN : ST_EMIT;
        end
      end
      ST_MEAN: begin
        state_nxt = ST_ANGLE;
      end
      ST_ANGLE: begin
        if (stat.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.take       = in_valid;
        cmd.mean_start = in_valid && stat.avg_done;
      end
      ST_MEAN:  cmd.angle_start = 1'b1;
      ST_ANGLE: cmd.apply       = stat.div_done;
      ST_EMIT:  cmd.load_out    = stat.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/fsspc_dp.sv
`default_nettype none

module fsspc_dp #(
  parameter int CHANNELS        = 5,
  parameter int AVERAGE_SAMPLES = 4,
  parameter int FRAME_TICKS     = 1000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fsspc_pkg::ctrl_cmd_t             cmd,
  output fsspc_pkg::dp_stat_t              stat,
  input  logic [fsspc_pkg::RAW_W-1:0]      cal_flat,
  input  logic [fsspc_pkg::RAW_W-1:0]      cal_bent,
  input  logic [fsspc_pkg::DB_W-1:0]       deadband_degrees,
  input  logic                             in_op,
  input  logic [fsspc_pkg::CH_FIELD_W-1:0] in_channel,
  input  logic [fsspc_pkg::RAW_W-1:0]      in_raw_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fsspc_pkg::LINES_W-1:0]    out_servo_lines,
  output logic                             out_angle_valid,
  output logic [fsspc_pkg::ANGLE_W-1:0]    out_finger_angle,
  output logic                             out_pulse_updated
);
  import fsspc_pkg::*;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W   = RAW_W + $clog2(AVERAGE_SAMPLES);
  localparam int CNT_W   = (AVERAGE_SAMPLES > 1) ? $clog2(AVERAGE_SAMPLES) : 1;
  localparam int FRAME_W = $clog2(FRAME_TICKS);

  // mean by reciprocal multiply, exact for every sum below 2^SUM_W
  localparam int MEAN_L  = (AVERAGE_SAMPLES > 1) ? $clog2(AVERAGE_SAMPLES) : 0;
  localparam int MEAN_SH = SUM_W + MEAN_L;
  localparam int MEAN_M  = ((1 << MEAN_SH) + AVERAGE_SAMPLES - 1) / AVERAGE_SAMPLES;
  localparam int MEAN_PW = SUM_W + MEAN_SH + 1;

  // per-channel state
  logic [SUM_W-1:0]   sum_r  [CHANNELS];
  logic [SUM_W-1:0]   sum_nxt[CHANNELS];
  logic [CNT_W-1:0]   cnt_r  [CHANNELS];
  logic [CNT_W-1:0]   cnt_nxt[CHANNELS];
  logic [ANGLE_W-1:0] last_r  [CHANNELS];
  logic [ANGLE_W-1:0] last_nxt[CHANNELS];
  logic [PW_W-1:0]    pw_r  [CHANNELS];
  logic [PW_W-1:0]    pw_nxt[CHANNELS];

  // frame state
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [CHANNELS-1:0] line_r, line_nxt;

  // item context
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [RAW_W-1:0]   mean_r, mean_nxt;
  logic               neg_r, neg_nxt;
  logic               dz_r, dz_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [ANGLE_W-1:0] res_angle_r, res_angle_nxt;
  logic               res_upd_r, res_upd_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [LINES_W-1:0] out_lines_r;
  logic               out_av_r;
  logic [ANGLE_W-1:0] out_angle_r;
  logic               out_upd_r;

  logic [CH_W-1:0]     ch_idx;
  logic                ch_ok;
  logic                is_sample;
  logic [SUM_W-1:0]    sum_total;
  logic                avg_done;
  logic [CHANNELS-1:0] lines_tick;
  logic [FRAME_W-1:0]  frame_inc;

  logic [MEAN_PW-1:0]      mean_prod;
  logic [RAW_W-1:0]        mean_calc;
  logic signed [RAW_W:0]   diff_m;
  logic signed [RAW_W:0]   den;
  logic signed [DVD_W:0]   num;
  logic [DVD_W-1:0]        num_mag;
  logic [DVS_W-1:0]        den_mag;

  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic                div_done;
  logic [DVD_W-1:0]    div_quo;

  logic [ANGLE_W-1:0] angle;
  logic [ANGLE_W-1:0] angle_diff;
  logic               upd;
  logic [PROD_W-1:0]  pw_prod;
  logic [PW_W-1:0]    pw_new;

  // input decode
  assign ch_idx    = in_channel[CH_W-1:0];
  assign ch_ok     = {1'b0, in_channel} < (CH_FIELD_W + 1)'(CHANNELS);
  assign is_sample = in_op == OP_SAMPLE;
  assign sum_total = sum_r[ch_idx] + SUM_W'(in_raw_sample);
  assign avg_done  = is_sample && ch_ok && (cnt_r[ch_idx] == CNT_W'(AVERAGE_SAMPLES - 1));

  // truncated mean of the closing sum
  assign mean_prod = MEAN_PW'(sum_total) * MEAN_PW'(MEAN_M);
  assign mean_calc = RAW_W'(mean_prod >> MEAN_SH);

  // servo lines after one tick
  always_comb begin
    lines_tick = (frame_r == '0) ? '1 : line_r;
    for (int i = 0; i < CHANNELS; i++) begin
      if (frame_r >= FRAME_W'(pw_r[i])) begin
        lines_tick[i] = 1'b0;
      end
    end
    frame_inc = (frame_r == FRAME_W'(FRAME_TICKS - 1)) ? '0 : frame_r + 1'b1;
  end

  // signed angle setup from the mean
  always_comb begin
    diff_m  = $signed({1'b0, mean_r}) - $signed({1'b0, cal_flat});
    den     = $signed({1'b0, cal_bent}) - $signed({1'b0, cal_flat});
    num     = (DVD_W + 1)'(diff_m) * (DVD_W + 1)'(signed'(ANGLE_SPAN));
    num_mag = num[DVD_W] ? DVD_W'(-num) : num[DVD_W-1:0];
    den_mag = den[RAW_W] ? DVS_W'(-den) : den[DVS_W-1:0];
  end

  // divider works on magnitudes, sign handled by the clamp
  assign div_start    = cmd.angle_start;
  assign div_dividend = num_mag;
  assign div_divisor  = den_mag;

  fsspc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // clamp, deadband and pulse width
  always_comb begin
    if (neg_r || dz_r) begin
      angle = '0;
    end else if (div_quo > DVD_W'(ANGLE_SPAN)) begin
      angle = ANGLE_W'(ANGLE_SPAN);
    end else begin
      angle = div_quo[ANGLE_W-1:0];
    end
    angle_diff = (angle >= last_r[ch_r]) ? angle - last_r[ch_r] : last_r[ch_r] - angle;
    upd        = angle_diff >= deadband_degrees;
    pw_prod    = PROD_W'(angle) * PROD_W'(TICK_RECIP);
    pw_new     = PW_W'(PULSE_RESET) + PW_W'(pw_prod >> RECIP_SHIFT);
  end

  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    pw_nxt        = pw_r;
    frame_nxt     = frame_r;
    line_nxt      = line_r;
    ch_nxt        = ch_r;
    mean_nxt      = mean_r;
    neg_nxt       = neg_r;
    dz_nxt        = dz_r;
    res_valid_nxt = res_valid_r;
    res_angle_nxt = res_angle_r;
    res_upd_nxt   = res_upd_r;

    if (cmd.take) begin
      ch_nxt        = ch_idx;
      res_valid_nxt = 1'b0;
      res_angle_nxt = '0;
      res_upd_nxt   = 1'b0;
      if (!is_sample) begin
        line_nxt  = lines_tick;
        frame_nxt = frame_inc;
      end else if (ch_ok) begin
        if (avg_done) begin
          sum_nxt[ch_idx] = '0;
          cnt_nxt[ch_idx] = '0;
        end else begin
          sum_nxt[ch_idx] = sum_total;
          cnt_nxt[ch_idx] = cnt_r[ch_idx] + 1'b1;
        end
      end
    end

    if (cmd.mean_start) begin
      mean_nxt = mean_calc;
    end

    if (cmd.angle_start) begin
      neg_nxt = num[DVD_W] ^ den[RAW_W];
      dz_nxt  = den == '0;
    end

    if (cmd.apply) begin
      res_valid_nxt = 1'b1;
      res_angle_nxt = angle;
      res_upd_nxt   = upd;
      if (upd) begin
        last_nxt[ch_r] = angle;
        pw_nxt[ch_r]   = pw_new;
      end
    end
  end

  assign stat.avg_done = avg_done;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        cnt_r[i]  <= '0;
        last_r[i] <= '0;
        pw_r[i]   <= PW_W'(PULSE_RESET);
      end
      frame_r     <= '0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      pw_r        <= pw_nxt;
      frame_r     <= frame_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r        <= ch_nxt;
    mean_r      <= mean_nxt;
    neg_r       <= neg_nxt;
    dz_r        <= dz_nxt;
    res_valid_r <= res_valid_nxt;
    res_angle_r <= res_angle_nxt;
    res_upd_r   <= res_upd_nxt;
    if (cmd.load_out) begin
      out_lines_r <= LINES_W'(line_r);
      out_av_r    <= res_valid_r;
      out_angle_r <= res_angle_r;
      out_upd_r   <= res_upd_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_servo_lines   = out_lines_r;
  assign out_angle_valid   = out_av_r;
  assign out_finger_angle  = out_angle_r;
  assign out_pulse_updated = out_upd_r;

endmodule

`default_nettype wire

// File: sv/flex_sensor_servo_pwm_controller.sv
// flex sensor to servo pwm controller
// in_ch takes one word per event: op 0 is a 20 us timer tick, op 1 an adc
// sample for finger channel 'channel'. every input word returns exactly one
// word on out_ch carrying the servo line levels after that event, plus the
// averaged angle and pulse-update flags when a sample closed an average.
// words are handled one at a time. a tick or a sample that does not close an
// average goes from accept through the emit state to the output register. a
// sample that closes an average has its mean latched by a reciprocal multiply
// at accept, then goes through the mean, angle (bit-serial angle divider) and
// emit states. the output register frees the core once loaded; in_ch.ready is
// high again the cycle after the result is loaded. a stalled out_ch holds its
// word and the next result waits in the core until the receiver takes it.
// calibration and deadband sit on an apb-style port and must be written only
// while idle; the block itself has no check for it. rst_n (synchronous,
// active low) restores calibration defaults, pulse widths of 50 ticks, zero
// angles, sums, counts, frame counter and all lines low.
`default_nettype none

module flex_sensor_servo_pwm_controller #(
  parameter int CHANNELS        = 5,
  parameter int AVERAGE_SAMPLES = 4,
  parameter int FRAME_TICKS     = 1000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fsspc_in_if.sink                         in_ch,
  fsspc_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fsspc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fsspc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fsspc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import fsspc_pkg::*;

  // calibration registers
  logic [RAW_W-1:0] cal_flat_r, cal_flat_nxt;
  logic [RAW_W-1:0] cal_bent_r, cal_bent_nxt;
  logic [DB_W-1:0]  deadband_r, deadband_nxt;

  logic       cfg_wr;
  logic [1:0] cfg_reg;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // apb: no wait states, write lands in the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = paddr[3:2];

  always_comb begin
    cal_flat_nxt = cal_flat_r;
    cal_bent_nxt = cal_bent_r;
    deadband_nxt = deadband_r;
    if (cfg_wr) begin
      case (cfg_reg)
        REG_CAL_FLAT: cal_flat_nxt = pwdata[RAW_W-1:0];
        REG_CAL_BENT: cal_bent_nxt = pwdata[RAW_W-1:0];
        REG_DEADBAND: deadband_nxt = pwdata[DB_W-1:0];
        default:      cal_flat_nxt = cal_flat_r;  // unmapped address, dropped
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_reg)
      REG_CAL_FLAT: prdata = CFG_DATA_W'(cal_flat_r);
      REG_CAL_BENT: prdata = CFG_DATA_W'(cal_bent_r);
      REG_DEADBAND: prdata = CFG_DATA_W'(deadband_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_flat_r <= CAL_FLAT_RESET;
      cal_bent_r <= CAL_BENT_RESET;
      deadband_r <= DEADBAND_RESET;
    end else begin
      cal_flat_r <= cal_flat_nxt;
      cal_bent_r <= cal_bent_nxt;
      deadband_r <= deadband_nxt;
    end
  end

  // sequencer: accept, mean latch, angle divide, emit
  fsspc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // per-channel averaging, angle math, pulse widths, frame counter
  fsspc_dp #(
    .CHANNELS        (CHANNELS),
    .AVERAGE_SAMPLES (AVERAGE_SAMPLES),
    .FRAME_TICKS     (FRAME_TICKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cal_flat          (cal_flat_r),
    .cal_bent          (cal_bent_r),
    .deadband_degrees  (deadband_r),
    .in_op             (in_ch.op),
    .in_channel        (in_ch.channel),
    .in_raw_sample     (in_ch.raw_sample),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_servo_lines   (out_ch.servo_lines),
    .out_angle_valid   (out_ch.angle_valid),
    .out_finger_angle  (out_ch.finger_angle),
    .out_pulse_updated (out_ch.pulse_updated)
  );

endmodule

`default_nettype wire

// File: sv/fsspc_checker.sv
`default_nettype none

`include "flex_sensor_servo_pwm_controller_assert.svh"

module fsspc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [fsspc_pkg::LINES_W-1:0]    servo_lines,
  input logic                             angle_valid,
  input logic [fsspc_pkg::ANGLE_W-1:0]    finger_angle,
  input logic                             pulse_updated
);
  import fsspc_pkg::*;

  // stalled result holds
  `FSSPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(servo_lines) && $stable(angle_valid) && $stable(finger_angle) && $stable(pulse_updated))

  // one word in flight: ready drops after an accept
  `FSSPC_ASSERT_NEXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready)

  // no angle means zero angle and no update
  `FSSPC_ASSERT_IMPL(a_no_angle, clk, rst_n, out_valid && !angle_valid, finger_angle == '0 && !pulse_updated)

  // angle stays in range
  `FSSPC_ASSERT_IMPL(a_angle_range, clk, rst_n, out_valid, finger_angle <= ANGLE_W'(ANGLE_SPAN))

endmodule

bind flex_sensor_servo_pwm_controller fsspc_checker u_fsspc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .servo_lines   (out_ch.servo_lines),
  .angle_valid   (out_ch.angle_valid),
  .finger_angle  (out_ch.finger_angle),
  .pulse_updated (out_ch.pulse_updated)
);

`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsspc_pkg::*;

  // block sizes and pulse arithmetic, kept apart from the rtl
  localparam int N_CH       = 5;
  localparam int AVG_N      = 4;
  localparam int FRAME_LEN  = 1000;
  localparam int SPAN_DEG   = 90;
  localparam int PULSE_BASE = 1000;
  localparam int TICK_US    = 20;
  localparam int PW_START   = 50;

  // one result word as the block returns it
  typedef struct packed {
    logic [LINES_W-1:0] lines;
    logic               valid;
    logic [ANGLE_W-1:0] angle;
    logic               updated;
  } servo_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fsspc_in_if  in_ch ();
  fsspc_out_if out_ch ();

  flex_sensor_servo_pwm_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted servo state
  int          pw_ticks [N_CH];
  int          held_angle [N_CH];
  int          acc_sum [N_CH];
  int          acc_cnt [N_CH];
  int          frame_pos;
  logic [4:0]  line_lvl;

  // predicted calibration registers
  int          cal_ext;
  int          cal_closed;
  int          deadband;

  // words predicted but not yet seen on out_ch, oldest first
  servo_word_t servo_words_due [$];

  // traffic shaping knobs
  bit          gaps_on;
  bit          stalls_on;
  int          burst_left;
  int          ready_run;

  // run statistics
  int          mismatch_count;
  int          words_sent;
  int          ticks_sent;
  int          samples_sent;
  int          stray_samples;
  int          averages;
  int          pulse_updates;
  int          frame_wraps;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs a handshake
  initial begin
    #15ms;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at %0d ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // signed, truncating interpolation between the two calibration points
  function automatic int angle_of(int mean);
    int den;
    int a;
    den = cal_closed - cal_ext;
    if (den == 0) return 0;
    a = ((mean - cal_ext) * SPAN_DEG) / den;
    if (a < 0) a = 0;
    if (a > SPAN_DEG) a = SPAN_DEG;
    return a;
  endfunction

  // advance the predicted state by one input word and return the result word
  function automatic servo_word_t next_servo_word(logic op, logic [2:0] ch,
                                                  logic [RAW_W-1:0] raw);
    servo_word_t w;
    int          mean;
    int          ang;
    int          diff;
    w = '0;
    if (op == OP_TICK) begin
      ticks_sent++;
      // all lines rise at frame start, each falls once its width is reached
      if (frame_pos == 0) line_lvl = '1;
      for (int i = 0; i < N_CH; i++)
        if (frame_pos >= pw_ticks[i]) line_lvl[i] = 1'b0;
      frame_pos++;
      if (frame_pos >= FRAME_LEN) begin
        frame_pos = 0;
        frame_wraps++;
      end
    end else if (ch < N_CH) begin
      samples_sent++;
      acc_sum[ch] += raw;
      acc_cnt[ch]++;
      if (acc_cnt[ch] >= AVG_N) begin
        mean = acc_sum[ch] / AVG_N;
        acc_sum[ch] = 0;
        acc_cnt[ch] = 0;
        ang = angle_of(mean);
        w.valid = 1'b1;
        w.angle = ANGLE_W'(ang);
        averages++;
        diff = (ang >= held_angle[ch]) ? ang - held_angle[ch] : held_angle[ch] - ang;
        if (diff >= deadband) begin
          held_angle[ch] = ang;
          pw_ticks[ch] = (PULSE_BASE + ang * 1000 / SPAN_DEG) / TICK_US;
          w.updated = 1'b1;
          pulse_updates++;
        end
      end
    end else begin
      // channel beyond the finger count: nothing moves
      stray_samples++;
    end
    w.lines = line_lvl;
    return w;
  endfunction

  // compare one accepted word against the oldest prediction
  task automatic check_word();
    servo_word_t want;
    if (servo_words_due.size() == 0) begin
      report_mismatch("word with nothing due, servo_lines", out_ch.servo_lines, 0);
      return;
    end
    want = servo_words_due.pop_front();
    if (out_ch.servo_lines !== want.lines)
      report_mismatch("servo_lines", out_ch.servo_lines, want.lines);
    if (out_ch.angle_valid !== want.valid)
      report_mismatch("angle_valid", out_ch.angle_valid, want.valid);
    if (out_ch.finger_angle !== want.angle)
      report_mismatch("finger_angle", out_ch.finger_angle, want.angle);
    if (out_ch.pulse_updated !== want.updated)
      report_mismatch("pulse_updated", out_ch.pulse_updated, want.updated);
  endtask

  // receiver: checks each accepted word, ready toggles in runs of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_run = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      if (!stalls_on) begin
        out_ch.ready <= 1'b1;
      end else if (ready_run > 0) begin
        ready_run--;
      end else if (out_ch.ready) begin
        out_ch.ready <= 1'b0;
        ready_run = $urandom_range(0, 5);
      end else begin
        out_ch.ready <= 1'b1;
        ready_run = $urandom_range(0, 11);
      end
    end
  end

  // offer one word, predict it once taken; with gaps on, bursts end in a random gap
  task automatic send_word(logic op, logic [2:0] ch, logic [RAW_W-1:0] raw);
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.channel    <= ch;
    in_ch.raw_sample <= raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    servo_words_due.push_back(next_servo_word(op, ch, raw));
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop offering words and let every due word come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (servo_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_check(logic [1:0] idx, int want);
    int mask;
    mask = (idx == REG_DEADBAND) ? 32'h7f : 32'h3ff;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (want & mask))
      report_mismatch($sformatf("readback of register %0d", idx), prdata & mask, want & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // apb write with junk in the unused upper data bits, then read it back
  task automatic write_reg(logic [1:0] idx, int value);
    int mask;
    mask = (idx == REG_DEADBAND) ? 32'h7f : 32'h3ff;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~mask) | (value & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CAL_FLAT: cal_ext    = value & mask;
      REG_CAL_BENT: cal_closed = value & mask;
      REG_DEADBAND: deadband   = value & mask;
      default: ;
    endcase
    penable <= 1'b0;
    @(posedge clk);
    read_check(idx, value);
  endtask

  task automatic set_calibration(int ext, int closed, int db);
    settle();
    write_reg(REG_CAL_FLAT, ext);
    write_reg(REG_CAL_BENT, closed);
    write_reg(REG_DEADBAND, db);
  endtask

  // mostly ticks and four-sample runs on one finger around a level mostly inside
  // the calibration window, plus stray channels and lone samples
  task automatic run_traffic(int n);
    int sent;
    int r;
    int reps;
    int ch;
    int lo;
    int hi;
    int lvl;
    int v;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_word(OP_TICK, 3'($urandom), RAW_W'($urandom));
        sent++;
      end else if (r < 55) begin
        // a run of ticks sweeps the frame counter through the pulse edges
        reps = $urandom_range(5, 30);
        repeat (reps) send_word(OP_TICK, 3'($urandom), RAW_W'($urandom));
        sent += reps;
      end else if (r < 60) begin
        send_word(OP_SAMPLE, 3'($urandom_range(N_CH, 7)), RAW_W'($urandom));
        sent++;
      end else if (r < 90) begin
        ch = $urandom_range(0, N_CH - 1);
        lo = (cal_ext < cal_closed) ? cal_ext : cal_closed;
        hi = (cal_ext < cal_closed) ? cal_closed : cal_ext;
        lvl = ($urandom_range(0, 9) < 7) ? $urandom_range(hi, lo) : $urandom_range(0, 1023);
        repeat (AVG_N) begin
          v = lvl + int'($urandom_range(0, 16)) - 8;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
          send_word(OP_SAMPLE, 3'(ch), RAW_W'(v));
        end
        sent += AVG_N;
      end else begin
        send_word(OP_SAMPLE, 3'($urandom_range(0, N_CH - 1)), RAW_W'($urandom));
        sent++;
      end
    end
  endtask

  // reset values of the registers, then hand-picked words at the reset setting
  task automatic test_directed_corners();
    read_check(REG_CAL_FLAT, CAL_FLAT_RESET);
    read_check(REG_CAL_BENT, CAL_BENT_RESET);
    read_check(REG_DEADBAND, DEADBAND_RESET);
    // first tick raises every line
    send_word(OP_TICK, 3'd7, 10'h3ff);
    // stray channels are ignored
    send_word(OP_SAMPLE, 3'd5, 10'h3ff);
    send_word(OP_SAMPLE, 3'd6, 10'h000);
    send_word(OP_SAMPLE, 3'd7, 10'h2aa);
    // full scale maps past the extended end: angle 0, inside the deadband
    repeat (4) send_word(OP_SAMPLE, 3'd0, 10'h3ff);
    // zero reads past the closed end: clamped to 90, widest pulse
    repeat (4) send_word(OP_SAMPLE, 3'd1, 10'h000);
    // exactly the closed reading: 90 with no clamping
    repeat (4) send_word(OP_SAMPLE, 3'd3, CAL_BENT_RESET);
    send_word(OP_SAMPLE, 3'd2, 10'h2aa);
    send_word(OP_SAMPLE, 3'd2, 10'h155);
    send_word(OP_SAMPLE, 3'd2, 10'd150);
    send_word(OP_SAMPLE, 3'd2, 10'd150);
    // partial average interleaved with a tick
    send_word(OP_SAMPLE, 3'd4, 10'h3ff);
    send_word(OP_TICK, 3'd0, 10'h000);
    send_word(OP_SAMPLE, 3'd4, 10'h000);
    send_word(OP_SAMPLE, 3'd4, 10'h155);
    send_word(OP_SAMPLE, 3'd4, 10'h2aa);
  endtask

  // full-range, reversed, equal and ordinary calibration points
  task automatic test_calibration_extremes();
    int ext_pts[4]    = '{0, 1023, 500, 300};
    int closed_pts[4] = '{1023, 0, 500, 900};
    for (int p = 0; p < 4; p++) begin
      set_calibration(ext_pts[p], closed_pts[p], $urandom_range(0, 3));
      run_traffic(110);
    end
  endtask

  // deadband zero, ninety and all ones
  task automatic test_deadband_limits();
    int db_pts[3] = '{0, 90, 127};
    for (int p = 0; p < 3; p++) begin
      set_calibration($urandom_range(0, 1023), $urandom_range(0, 1023), db_pts[p]);
      run_traffic(110);
    end
  endtask

  // no sender gaps and no receiver stalls
  task automatic test_back_to_back();
    set_calibration($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 5));
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_traffic(200);
    settle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // random settings, mostly small deadbands
  task automatic test_random_traffic();
    int db;
    for (int p = 0; p < 5; p++) begin
      db = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
      set_calibration($urandom_range(0, 1023), $urandom_range(0, 1023), db);
      run_traffic(170);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_TICK;
    in_ch.channel    <= '0;
    in_ch.raw_sample <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    burst_left = 0;
    // predicted state after reset
    for (int i = 0; i < N_CH; i++) begin
      pw_ticks[i]   = PW_START;
      held_angle[i] = 0;
      acc_sum[i]    = 0;
      acc_cnt[i]    = 0;
    end
    frame_pos  = 0;
    line_lvl   = '0;
    cal_ext    = CAL_FLAT_RESET;
    cal_closed = CAL_BENT_RESET;
    deadband   = DEADBAND_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_calibration_extremes();
    test_deadband_limits();
    test_back_to_back();
    test_random_traffic();

    // drain, then give a late or extra word time to show up
    in_ch.valid <= 1'b0;
    for (int k = 0; k < 20000 && servo_words_due.size() != 0; k++) @(posedge clk);
    repeat (60) @(posedge clk);
    if (servo_words_due.size() != 0)
      report_mismatch("words still due at end", servo_words_due.size(), 0);

    $display("summary: %0d words (%0d ticks, %0d samples, %0d stray channel), %0d frame wraps",
             words_sent, ticks_sent, samples_sent, stray_samples, frame_wraps);
    $display("summary: %0d averages, %0d pulse width updates, %0d mismatches",
             averages, pulse_updates, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/fsspc_pkg.sv
sv/fsspc_if.sv
sv/fsspc_div.sv
sv/fsspc_ctrl.sv
sv/fsspc_dp.sv
sv/flex_sensor_servo_pwm_controller.sv
sv/fsspc_checker.sv
test/tb_top.sv
